// ----- design/udc_pkg.sv -----
// shared types, reciprocal constants and month table for the unix time to calendar pipeline
package udc_pkg;

    localparam int STAGES = 8;

    typedef logic [STAGES-1:0] stage_en_t;

    localparam int SECS_W  = 32;
    localparam int DAYS_W  = 16;
    localparam int SOD_W   = 17;
    localparam int REM_W   = 12;
    localparam int Z_W     = 20;
    localparam int DOE_W   = 18;
    localparam int YOE_W   = 9;
    localparam int DOY_W   = 9;
    localparam int MP_W    = 4;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    // seconds / 86400 = (seconds >> 7) / 675
    localparam int DAY_PRE    = 7;
    localparam int DAY_SHIFT  = 35;
    localparam logic [25:0] DAY_RECIP =
        26'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);

    localparam int HOUR_SHIFT = 29;
    localparam logic [17:0] HOUR_RECIP =
        18'(((64'd1 << HOUR_SHIFT) + 64'd3599) / 64'd3600);

    localparam int MIN_SHIFT = 18;
    localparam logic [12:0] MIN_RECIP =
        13'(((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60);

    localparam int Q4Y_SHIFT = 29;
    localparam logic [18:0] Q4Y_RECIP =
        19'(((64'd1 << Q4Y_SHIFT) + 64'd1459) / 64'd1460);

    localparam int YEAR_SHIFT = 27;
    localparam logic [18:0] YEAR_RECIP =
        19'(((64'd1 << YEAR_SHIFT) + 64'd364) / 64'd365);

    localparam int MP_SHIFT = 19;
    localparam logic [11:0] MP_RECIP =
        12'(((64'd1 << MP_SHIFT) + 64'd152) / 64'd153);

    // day numbers counted from 0000-03-01
    localparam logic [Z_W-1:0] EPOCH_SHIFT = 20'd719468;
    localparam logic [Z_W-1:0] ERA4_START  = 20'd584388;
    localparam logic [Z_W-1:0] ERA5_START  = 20'd730485;

    localparam logic [YEAR_W-1:0] ERA4_YEAR = 12'd1600;
    localparam logic [YEAR_W-1:0] ERA5_YEAR = 12'd2000;

    // first day of each month in a year starting on march 1
    function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] r;
        unique case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- design/udc_ctl.sv -----
// per-stage valid bits and load enables with bubble collapsing
module udc_ctl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output udc_pkg::stage_en_t en
);

    udc_pkg::stage_en_t valid_reg;
    udc_pkg::stage_en_t valid_next;

    always_comb
    begin
        en[udc_pkg::STAGES-1] = !valid_reg[udc_pkg::STAGES-1] || out_ready;
        for (int k = udc_pkg::STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < udc_pkg::STAGES; k++)
        begin
            if (en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[udc_pkg::STAGES-1];

endmodule

// ----- design/udc_secs.sv -----
// splits seconds into a day count and the time of day
module udc_secs
(
    input  logic                              clk,
    input  udc_pkg::stage_en_t                en,
    input  logic [udc_pkg::SECS_W-1:0]        unix_seconds,
    output logic [udc_pkg::DAYS_W-1:0]        days,
    output logic [udc_pkg::HOUR_W-1:0]        hour,
    output logic [udc_pkg::MIN_W-1:0]         minute,
    output logic [udc_pkg::SEC_W-1:0]         second
);

    // stage 1
    logic [50:0]                      day_prod;
    logic [udc_pkg::DAYS_W-1:0]       days_next, days_reg;
    logic [udc_pkg::SOD_W-1:0]        tlo_next, tlo_reg;
    // stage 2
    logic [udc_pkg::SOD_W-1:0]        sod2_next, sod2_reg;
    // stage 3
    logic [34:0]                      hour_prod;
    logic [udc_pkg::SOD_W-1:0]        sod3_reg;
    logic [udc_pkg::HOUR_W-1:0]       hh3_next, hh3_reg;
    // stage 4
    logic [udc_pkg::HOUR_W-1:0]       hh4_reg;
    logic [udc_pkg::REM_W-1:0]        rem4_next, rem4_reg;
    // stage 5
    logic [24:0]                      min_prod;
    logic [udc_pkg::HOUR_W-1:0]       hh5_reg;
    logic [udc_pkg::REM_W-1:0]        rem5_reg;
    logic [udc_pkg::MIN_W-1:0]        mi5_next, mi5_reg;
    // stage 6..8
    logic [udc_pkg::HOUR_W-1:0]       hh6_reg, hh7_reg, hh8_reg;
    logic [udc_pkg::MIN_W-1:0]        mi6_reg, mi7_reg, mi8_reg;
    logic [udc_pkg::SEC_W-1:0]        ss6_next, ss6_reg, ss7_reg, ss8_reg;

    always_comb
    begin
        day_prod  = 51'(unix_seconds[udc_pkg::SECS_W-1:udc_pkg::DAY_PRE])
                  * 51'(udc_pkg::DAY_RECIP);
        days_next = day_prod[udc_pkg::DAY_SHIFT +: udc_pkg::DAYS_W];
        tlo_next  = unix_seconds[udc_pkg::SOD_W-1:0];

        sod2_next = tlo_reg - 17'(33'(days_reg) * 33'd86400);

        hour_prod = 35'(sod2_reg) * 35'(udc_pkg::HOUR_RECIP);
        hh3_next  = hour_prod[udc_pkg::HOUR_SHIFT +: udc_pkg::HOUR_W];

        rem4_next = 12'(sod3_reg - 17'(17'(hh3_reg) * 17'd3600));

        min_prod  = 25'(rem4_reg) * 25'(udc_pkg::MIN_RECIP);
        mi5_next  = min_prod[udc_pkg::MIN_SHIFT +: udc_pkg::MIN_W];

        ss6_next  = 6'(rem5_reg - 12'(12'(mi5_reg) * 12'd60));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            days_reg <= days_next;
            tlo_reg  <= tlo_next;
        end
        if (en[1])
        begin
            sod2_reg <= sod2_next;
        end
        if (en[2])
        begin
            sod3_reg <= sod2_reg;
            hh3_reg  <= hh3_next;
        end
        if (en[3])
        begin
            hh4_reg  <= hh3_reg;
            rem4_reg <= rem4_next;
        end
        if (en[4])
        begin
            hh5_reg  <= hh4_reg;
            rem5_reg <= rem4_reg;
            mi5_reg  <= mi5_next;
        end
        if (en[5])
        begin
            hh6_reg <= hh5_reg;
            mi6_reg <= mi5_reg;
            ss6_reg <= ss6_next;
        end
        if (en[6])
        begin
            hh7_reg <= hh6_reg;
            mi7_reg <= mi6_reg;
            ss7_reg <= ss6_reg;
        end
        if (en[7])
        begin
            hh8_reg <= hh7_reg;
            mi8_reg <= mi7_reg;
            ss8_reg <= ss7_reg;
        end
    end

    assign days   = days_reg;
    assign hour   = hh8_reg;
    assign minute = mi8_reg;
    assign second = ss8_reg;

endmodule

// ----- design/udc_date.sv -----
// day count to gregorian year, month and day, march-based years
module udc_date
(
    input  logic                              clk,
    input  udc_pkg::stage_en_t                en,
    input  logic [udc_pkg::DAYS_W-1:0]        days,
    output logic [udc_pkg::YEAR_W-1:0]        year,
    output logic [udc_pkg::MONTH_W-1:0]       month,
    output logic [udc_pkg::DAY_W-1:0]         day
);

    // stage 2
    logic [udc_pkg::Z_W-1:0]          z;
    logic                             era5_next, era2_reg;
    logic [udc_pkg::DOE_W-1:0]        doe2_next, doe2_reg;
    // stage 3
    logic [36:0]                      q4y_prod;
    logic                             era3_reg;
    logic [udc_pkg::DOE_W-1:0]        doe3_reg;
    logic [6:0]                       a3_next, a3_reg;
    logic [2:0]                       b3_next, b3_reg;
    logic                             c3_next, c3_reg;
    // stage 4
    logic                             era4_reg;
    logic [udc_pkg::DOE_W-1:0]        doe4_reg;
    logic [udc_pkg::DOE_W-1:0]        num4_next, num4_reg;
    // stage 5
    logic [36:0]                      year_prod;
    logic                             era5_reg;
    logic [udc_pkg::DOE_W-1:0]        doe5_reg;
    logic [udc_pkg::YOE_W-1:0]        yoe5_next, yoe5_reg;
    // stage 6
    logic [1:0]                       q100;
    logic [udc_pkg::DOE_W-1:0]        yr_base;
    logic                             era6_reg;
    logic [udc_pkg::YOE_W-1:0]        yoe6_reg;
    logic [udc_pkg::DOY_W-1:0]        doy6_next, doy6_reg;
    // stage 7
    logic [10:0]                      mp_arg;
    logic [22:0]                      mp_prod;
    logic                             era7_reg;
    logic [udc_pkg::YOE_W-1:0]        yoe7_reg;
    logic [udc_pkg::DOY_W-1:0]        doy7_reg;
    logic [udc_pkg::MP_W-1:0]         mp7_next, mp7_reg;
    // stage 8
    logic [udc_pkg::YEAR_W-1:0]       year_next, year_reg;
    logic [udc_pkg::MONTH_W-1:0]      month_next, month_reg;
    logic [udc_pkg::DAY_W-1:0]        day_next, day_reg;

    always_comb
    begin
        z         = udc_pkg::Z_W'(days) + udc_pkg::EPOCH_SHIFT;
        era5_next = z >= udc_pkg::ERA5_START;
        doe2_next = 18'(z - (era5_next ? udc_pkg::ERA5_START : udc_pkg::ERA4_START));

        q4y_prod = 37'(doe2_reg) * 37'(udc_pkg::Q4Y_RECIP);
        a3_next  = q4y_prod[udc_pkg::Q4Y_SHIFT +: 7];
        priority if (doe2_reg >= 18'd146096) b3_next = 3'd4;
        else if (doe2_reg >= 18'd109572)     b3_next = 3'd3;
        else if (doe2_reg >= 18'd73048)      b3_next = 3'd2;
        else if (doe2_reg >= 18'd36524)      b3_next = 3'd1;
        else                                 b3_next = 3'd0;
        c3_next = doe2_reg == 18'd146096;

        num4_next = doe3_reg + 18'(b3_reg) - 18'(a3_reg) - 18'(c3_reg);

        year_prod = 37'(num4_reg) * 37'(udc_pkg::YEAR_RECIP);
        yoe5_next = year_prod[udc_pkg::YEAR_SHIFT +: udc_pkg::YOE_W];

        priority if (yoe5_reg >= 9'd300) q100 = 2'd3;
        else if (yoe5_reg >= 9'd200)     q100 = 2'd2;
        else if (yoe5_reg >= 9'd100)     q100 = 2'd1;
        else                             q100 = 2'd0;
        yr_base   = 18'(18'(yoe5_reg) * 18'd365) + 18'(yoe5_reg[8:2]) - 18'(q100);
        doy6_next = 9'(doe5_reg - yr_base);

        mp_arg   = 11'(11'(doy6_reg) * 11'd5 + 11'd2);
        mp_prod  = 23'(mp_arg) * 23'(udc_pkg::MP_RECIP);
        mp7_next = mp_prod[udc_pkg::MP_SHIFT +: udc_pkg::MP_W];

        day_next   = 5'(doy7_reg - udc_pkg::month_start(mp7_reg) + 9'd1);
        month_next = (mp7_reg < 4'd10) ? 4'(mp7_reg + 4'd3) : 4'(mp7_reg - 4'd9);
        year_next  = 12'(yoe7_reg) + (era7_reg ? udc_pkg::ERA5_YEAR : udc_pkg::ERA4_YEAR)
                   + ((mp7_reg >= 4'd10) ? 12'd1 : 12'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            era2_reg <= era5_next;
            doe2_reg <= doe2_next;
        end
        if (en[2])
        begin
            era3_reg <= era2_reg;
            doe3_reg <= doe2_reg;
            a3_reg   <= a3_next;
            b3_reg   <= b3_next;
            c3_reg   <= c3_next;
        end
        if (en[3])
        begin
            era4_reg <= era3_reg;
            doe4_reg <= doe3_reg;
            num4_reg <= num4_next;
        end
        if (en[4])
        begin
            era5_reg <= era4_reg;
            doe5_reg <= doe4_reg;
            yoe5_reg <= yoe5_next;
        end
        if (en[5])
        begin
            era6_reg <= era5_reg;
            yoe6_reg <= yoe5_reg;
            doy6_reg <= doy6_next;
        end
        if (en[6])
        begin
            era7_reg <= era6_reg;
            yoe7_reg <= yoe6_reg;
            doy7_reg <= doy6_reg;
            mp7_reg  <= mp7_next;
        end
        if (en[7])
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
        end
    end

    assign year  = year_reg;
    assign month = month_reg;
    assign day   = day_reg;

endmodule

// ----- design/unix_time_to_utc_calendar.sv -----
// top level: unix seconds to utc calendar date and time of day
//
//  port group   dir   payload
//  s_t*         in    unix_seconds
//  m_t*         out   year, month, day, hour, minute, second
//
// accepted items move through the register stages to m_tvalid; one item per cycle while m_tready is high
// eight register stages, each with one constant-reciprocal multiply or add/compare
// reset clears only the stage valid bits; the datapath registers have no reset
// a stage loads whenever it is empty or the stage after it moves, so bubbles
// close up and s_tready stays high while any stage is free
module unix_time_to_utc_calendar
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [udc_pkg::IN_TDATA_W-1:0]    s_tdata,   // [31:0] unix_seconds
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [udc_pkg::OUT_TDATA_W-1:0]   m_tdata    // [11:0] year, [15:12] month,
                                                         // [20:16] day, [25:21] hour,
                                                         // [31:26] minute, [37:32] second
);

    udc_pkg::stage_en_t                en;
    logic [udc_pkg::DAYS_W-1:0]        days;
    logic [udc_pkg::YEAR_W-1:0]        year;
    logic [udc_pkg::MONTH_W-1:0]       month;
    logic [udc_pkg::DAY_W-1:0]         day;
    logic [udc_pkg::HOUR_W-1:0]        hour;
    logic [udc_pkg::MIN_W-1:0]         minute;
    logic [udc_pkg::SEC_W-1:0]         second;

    udc_ctl u_ctl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .en        (en)
    );

    udc_secs u_secs
    (
        .clk          (clk),
        .en           (en),
        .unix_seconds (s_tdata),
        .days         (days),
        .hour         (hour),
        .minute       (minute),
        .second       (second)
    );

    udc_date u_date
    (
        .clk   (clk),
        .en    (en),
        .days  (days),
        .year  (year),
        .month (month),
        .day   (day)
    );

    assign m_tdata = {2'b00, second, minute, hour, day, month, year};

endmodule

// ----- tb/tb_top.sv -----
// testbench for the unix seconds to utc calendar pipeline, self-checking with a date scoreboard
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned DAYS_IN_YEAR  = 365;
    localparam int unsigned DAYS_IN_ERA   = 146097;
    localparam int unsigned DAY_OF_EPOCH  = 719468;
    localparam int unsigned LAST_DAY      = 49709;
    localparam int          ITEMS_PER_RUN = 520;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          DRAIN_CYCLES  = 16;

    typedef struct packed {
        logic [udc_pkg::YEAR_W-1:0]  year;
        logic [udc_pkg::MONTH_W-1:0] month;
        logic [udc_pkg::DAY_W-1:0]   day;
        logic [udc_pkg::HOUR_W-1:0]  hour;
        logic [udc_pkg::MIN_W-1:0]   minute;
        logic [udc_pkg::SEC_W-1:0]   second;
    } utc_date_t;

    class calendar_scoreboard;
        utc_date_t expected_dates[$];
        int        failures;

        function new();
            failures = 0;
        endfunction

        function utc_date_t to_utc_date(logic [udc_pkg::SECS_W-1:0] secs);
            utc_date_t   d;
            int unsigned days, sod, z, era, doe, yoe, doy, mp, mm;
            days = secs / SECS_PER_DAY;
            sod  = secs - days * SECS_PER_DAY;
            d.hour   = udc_pkg::HOUR_W'(sod / SECS_PER_HOUR);
            d.minute = udc_pkg::MIN_W'((sod % SECS_PER_HOUR) / SECS_PER_MIN);
            d.second = udc_pkg::SEC_W'(sod % SECS_PER_MIN);
            // civil date with years starting in march, leap day last
            z   = days + DAY_OF_EPOCH;
            era = z / DAYS_IN_ERA;
            doe = z - era * DAYS_IN_ERA;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / DAYS_IN_YEAR;
            doy = doe - (DAYS_IN_YEAR * yoe + yoe / 4 - yoe / 100);
            mp  = (5 * doy + 2) / 153;
            mm  = (mp < 10) ? mp + 3 : mp - 9;
            d.day   = udc_pkg::DAY_W'(doy - (153 * mp + 2) / 5 + 1);
            d.month = udc_pkg::MONTH_W'(mm);
            d.year  = udc_pkg::YEAR_W'(yoe + era * 400 + ((mm <= 2) ? 1 : 0));
            return d;
        endfunction

        function void note_seconds(logic [udc_pkg::SECS_W-1:0] secs);
            expected_dates.push_back(to_utc_date(secs));
        endfunction

        function void report(string what);
            failures++;
            if (failures <= 10)
                $display("%0t: %s", $realtime, what);
        endfunction

        function void check_date(logic [udc_pkg::OUT_TDATA_W-1:0] data);
            utc_date_t e, a;
            a.year   = data[11:0];
            a.month  = data[15:12];
            a.day    = data[20:16];
            a.hour   = data[25:21];
            a.minute = data[31:26];
            a.second = data[37:32];
            if (expected_dates.size() == 0)
            begin
                report($sformatf("unexpected item %0d-%0d-%0d %0d:%0d:%0d", a.year, a.month,
                                 a.day, a.hour, a.minute, a.second));
                return;
            end
            e = expected_dates.pop_front();
            if (a != e)
                report($sformatf({"date mismatch: expected %0d-%0d-%0d %0d:%0d:%0d",
                                  " got %0d-%0d-%0d %0d:%0d:%0d"},
                                 e.year, e.month, e.day, e.hour, e.minute, e.second,
                                 a.year, a.month, a.day, a.hour, a.minute, a.second));
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [udc_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [udc_pkg::OUT_TDATA_W-1:0] m_tdata;

    calendar_scoreboard sb = new();
    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count = 0;

    unix_time_to_utc_calendar u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_seconds(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_date(m_tdata);
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_seconds(input logic [udc_pkg::SECS_W-1:0] secs);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= secs;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [udc_pkg::SECS_W-1:0] random_seconds();
        logic [udc_pkg::SECS_W-1:0] day_start;
        day_start = udc_pkg::SECS_W'($urandom_range(0, LAST_DAY) * SECS_PER_DAY);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom();
            4:          return day_start;
            5:          return day_start + udc_pkg::SECS_W'(SECS_PER_DAY - 1);
            6:          return day_start + udc_pkg::SECS_W'($urandom_range(0, SECS_PER_DAY - 1));
            // near the top of the range, across the 2100 leap exception
            7:          return 32'hFFFF_FFFF - udc_pkg::SECS_W'($urandom_range(0, 200_000_000));
            8:          return 32'd4107542400 - udc_pkg::SECS_W'(SECS_PER_DAY * 3)
                               + udc_pkg::SECS_W'($urandom_range(0, SECS_PER_DAY * 6));
            default:    return 32'd951868800 - udc_pkg::SECS_W'(SECS_PER_DAY * 3)
                               + udc_pkg::SECS_W'($urandom_range(0, SECS_PER_DAY * 6));
        endcase
    endfunction

    initial
    begin
        logic [udc_pkg::SECS_W-1:0] directed[$];
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        send_idle_pct = 30;
        recv_idle_pct = 58;
        directed = '{32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                     32'd946684799, 32'd946684800, 32'd951782399, 32'd951782400,
                     32'd951868799, 32'd951868800, 32'd2147483647, 32'd2147483648,
                     32'd4107542399, 32'd4107542400, 32'd4291718399, 32'd4291718400,
                     32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF};
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_seconds(directed[i]);
        for (int run = 0; run < 3; run++)
        begin
            send_idle_pct = (run == 0) ? 30 : (run == 1) ? 58 : 0;
            recv_idle_pct = (run == 0) ? 58 : (run == 1) ? 30 : 0;
            repeat (ITEMS_PER_RUN)
                send_seconds(random_seconds());
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/udc_pkg.sv
design/udc_ctl.sv
design/udc_secs.sv
design/udc_date.sv
design/unix_time_to_utc_calendar.sv
tb/tb_top.sv
